// ===== hdl/fcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcs_pkg: flash command sequencer definitions
// Widths, command bytes, unlock addresses, mode and operation codes.
// ----------------------------------------------------------------------------
package fcs_pkg;

    localparam int ADDR_BITS = 24;
    localparam int DATA_BITS = 16;
    localparam int CMD_BITS  = 8;
    localparam int SIZE_W    = 5;
    localparam int MODE_W    = 3;
    localparam int KIND_W    = 3;

    localparam logic [ADDR_BITS-1:0] UNLOCK_A = ADDR_BITS'(32'h5555 * 2);
    localparam logic [ADDR_BITS-1:0] UNLOCK_B = ADDR_BITS'(32'h2aaa * 2);

    localparam logic [ADDR_BITS-1:0] SECTOR_ALIGN = ~ADDR_BITS'(32'h0000_1000 - 1);
    localparam logic [ADDR_BITS-1:0] BLOCK_ALIGN  = ~ADDR_BITS'(32'h0001_0000 - 1);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(ADDR_BITS);

    localparam logic [CMD_BITS-1:0] CMD_UNLOCK1 = 8'haa;
    localparam logic [CMD_BITS-1:0] CMD_UNLOCK2 = 8'h55;
    localparam logic [CMD_BITS-1:0] CMD_ERASE   = 8'h80;
    localparam logic [CMD_BITS-1:0] CMD_ID      = 8'h90;
    localparam logic [CMD_BITS-1:0] CMD_QUERY   = 8'h98;
    localparam logic [CMD_BITS-1:0] CMD_PROGRAM = 8'ha0;
    localparam logic [CMD_BITS-1:0] CMD_CHIP    = 8'h10;
    localparam logic [CMD_BITS-1:0] CMD_SECTOR  = 8'h30;
    localparam logic [CMD_BITS-1:0] CMD_BLOCK   = 8'h50;
    localparam logic [CMD_BITS-1:0] CMD_EXIT    = 8'hf0;

    localparam logic [MODE_W-1:0] M_CODE_NORMAL  = 3'd0;
    localparam logic [MODE_W-1:0] M_CODE_ENTER1  = 3'd1;
    localparam logic [MODE_W-1:0] M_CODE_ENTER2  = 3'd2;
    localparam logic [MODE_W-1:0] M_CODE_ENTER3  = 3'd3;
    localparam logic [MODE_W-1:0] M_CODE_ENTER4  = 3'd4;
    localparam logic [MODE_W-1:0] M_CODE_ENTER5  = 3'd5;
    localparam logic [MODE_W-1:0] M_CODE_QUERY   = 3'd6;
    localparam logic [MODE_W-1:0] M_CODE_PROGRAM = 3'd7;

    typedef enum logic [7:0] {
        MODE_NORMAL  = 8'b0000_0001,
        MODE_ENTER1  = 8'b0000_0010,
        MODE_ENTER2  = 8'b0000_0100,
        MODE_ENTER3  = 8'b0000_1000,
        MODE_ENTER4  = 8'b0001_0000,
        MODE_ENTER5  = 8'b0010_0000,
        MODE_QUERY   = 8'b0100_0000,
        MODE_PROGRAM = 8'b1000_0000
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        OP_NONE    = 3'd0,
        OP_PROGRAM = 3'd1,
        OP_SECTOR  = 3'd2,
        OP_BLOCK   = 3'd3,
        OP_CHIP    = 3'd4
    } op_kind_t;

    typedef struct packed {
        op_kind_t               kind;
        logic [ADDR_BITS-1:0]   address;
        logic [DATA_BITS-1:0]   data;
        mode_t                  next_mode;
        logic                   seq_error;
    } fcs_result_t;

    function automatic logic [MODE_W-1:0] mode_code(mode_t m);
        logic [MODE_W-1:0] c;
        case (m)
            MODE_NORMAL:  c = M_CODE_NORMAL;
            MODE_ENTER1:  c = M_CODE_ENTER1;
            MODE_ENTER2:  c = M_CODE_ENTER2;
            MODE_ENTER3:  c = M_CODE_ENTER3;
            MODE_ENTER4:  c = M_CODE_ENTER4;
            MODE_ENTER5:  c = M_CODE_ENTER5;
            MODE_QUERY:   c = M_CODE_QUERY;
            MODE_PROGRAM: c = M_CODE_PROGRAM;
            default:      c = M_CODE_NORMAL;
        endcase
        return c;
    endfunction

    function automatic logic [ADDR_BITS-1:0] size_mask(logic [SIZE_W-1:0] bits);
        logic [SIZE_W:0] eff;
        eff = {1'b0, bits};
        if (eff > (SIZE_W + 1)'(ADDR_BITS))
        begin
            eff = (SIZE_W + 1)'(ADDR_BITS);
        end
        return ~({ADDR_BITS{1'b1}} << eff);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/fcs_wr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcs_wr_if: bus write channel
// Valid/ready channel carrying one flash bus write (offset and halfword).
// ----------------------------------------------------------------------------
interface fcs_wr_if;
    logic                           valid;
    logic                           ready;
    logic [fcs_pkg::ADDR_BITS-1:0]  offset;
    logic [fcs_pkg::DATA_BITS-1:0]  wdata;

    modport source (output valid, output offset, output wdata, input ready);
    modport sink   (input valid, input offset, input wdata, output ready);
endinterface
`default_nettype wire

// ===== hdl/fcs_op_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcs_op_if: operation channel
// Valid/ready channel carrying the decoded array operation for one write.
// ----------------------------------------------------------------------------
interface fcs_op_if;
    logic                           valid;
    logic                           ready;
    logic [fcs_pkg::KIND_W-1:0]     op_kind;
    logic [fcs_pkg::ADDR_BITS-1:0]  op_address;
    logic [fcs_pkg::DATA_BITS-1:0]  op_data;
    logic [fcs_pkg::MODE_W-1:0]     mode;
    logic                           seq_error;

    modport source (output valid, output op_kind, output op_address, output op_data,
                    output mode, output seq_error, input ready);
    modport sink   (input valid, input op_kind, input op_address, input op_data,
                    input mode, input seq_error, output ready);
endinterface
`default_nettype wire

// ===== hdl/flash_command_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// flash_command_sequencer: parallel NOR flash command sequencer
// Decodes JEDEC-style unlock/command bus writes into array operations.
//
//   channel   direction  payload
//   wr        in         offset[23:0], wdata[15:0]
//   op        out        op_kind, op_address, op_data, mode, seq_error
//   cfg       in         cfg_we, cfg_wdata[4:0] (size_bits)
//
// The operation passes through an input register, the decode, then the result
// register. One item per cycle sustained while the op channel is ready;
// the mode register closes its loop through the combinational decode.
// Reset empties both stages, sets normal mode and a 16 MB size.
// A stalled op channel holds the result; the input stage still takes one item.
// ----------------------------------------------------------------------------
module flash_command_sequencer
(
    input  logic                        clk,
    input  logic                        rst_n,
    fcs_wr_if.sink                      wr,
    fcs_op_if.source                    op,
    input  logic                        cfg_we,
    input  logic [fcs_pkg::SIZE_W-1:0]  cfg_wdata
);

    logic                           in_valid_reg;
    logic [fcs_pkg::ADDR_BITS-1:0]  in_offset_reg;
    logic [fcs_pkg::DATA_BITS-1:0]  in_wdata_reg;

    logic                           res_valid_reg;
    fcs_pkg::op_kind_t              res_kind_reg;
    logic [fcs_pkg::ADDR_BITS-1:0]  res_address_reg;
    logic [fcs_pkg::DATA_BITS-1:0]  res_data_reg;
    logic [fcs_pkg::MODE_W-1:0]     res_mode_reg;
    logic                           res_error_reg;

    fcs_pkg::mode_t                 mode_reg;
    logic [fcs_pkg::ADDR_BITS-1:0]  mask_reg;

    logic                           advance;
    logic                           wr_fire;
    fcs_pkg::fcs_result_t           dec;

    assign advance  = in_valid_reg && (!res_valid_reg || op.ready);
    assign wr.ready = !in_valid_reg || advance;
    assign wr_fire  = wr.valid && wr.ready;

    fcs_decode u_decode
    (
        .mode   (mode_reg),
        .addr   (in_offset_reg & mask_reg),
        .data   (in_wdata_reg),
        .result (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= fcs_pkg::size_mask(fcs_pkg::SIZE_RESET);
            mode_reg      <= fcs_pkg::MODE_NORMAL;
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mask_reg <= fcs_pkg::size_mask(cfg_wdata);
            if (wr.ready)
                in_valid_reg <= wr.valid;
            if (advance)
            begin
                mode_reg      <= dec.next_mode;
                res_valid_reg <= 1'b1;
            end
            else if (op.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // hold payload unless its stage takes a new item
    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            in_offset_reg <= wr.offset;
            in_wdata_reg  <= wr.wdata;
        end
        if (advance)
        begin
            res_kind_reg    <= dec.kind;
            res_address_reg <= dec.address;
            res_data_reg    <= dec.data;
            res_mode_reg    <= fcs_pkg::mode_code(dec.next_mode);
            res_error_reg   <= dec.seq_error;
        end
    end

    assign op.valid      = res_valid_reg;
    assign op.op_kind    = res_kind_reg;
    assign op.op_address = res_address_reg;
    assign op.op_data    = res_data_reg;
    assign op.mode       = res_mode_reg;
    assign op.seq_error  = res_error_reg;

    a_stall_holds_mode: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !op.ready |=> $stable(mode_reg))
        else $error("mode advanced while the result stage was stalled");

    a_mode_matches: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_mode_reg == fcs_pkg::mode_code(mode_reg))
        else $error("reported mode differs from the mode register");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_error_reg |->
            res_kind_reg == fcs_pkg::OP_NONE && res_mode_reg == fcs_pkg::M_CODE_NORMAL)
        else $error("sequence error with an operation or a non-normal mode");

    a_op_returns_normal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_kind_reg != fcs_pkg::OP_NONE |->
            res_mode_reg == fcs_pkg::M_CODE_NORMAL && !res_error_reg)
        else $error("array operation not followed by normal mode");

endmodule
`default_nettype wire

// ===== hdl/fcs_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcs_decode: command decode
// Next mode and array operation for one masked bus write in the current mode.
// ----------------------------------------------------------------------------
module fcs_decode
(
    input  fcs_pkg::mode_t                  mode,
    input  logic [fcs_pkg::ADDR_BITS-1:0]   addr,
    input  logic [fcs_pkg::DATA_BITS-1:0]   data,
    output fcs_pkg::fcs_result_t            result
);

    logic [fcs_pkg::CMD_BITS-1:0] cmd;
    logic                         at_a;
    logic                         at_b;

    assign cmd  = data[fcs_pkg::CMD_BITS-1:0];
    assign at_a = (addr == fcs_pkg::UNLOCK_A);
    assign at_b = (addr == fcs_pkg::UNLOCK_B);

    always_comb
    begin
        result.kind      = fcs_pkg::OP_NONE;
        result.address   = '0;
        result.data      = '0;
        result.next_mode = fcs_pkg::MODE_NORMAL;
        result.seq_error = 1'b0;

        if (mode != fcs_pkg::MODE_PROGRAM && cmd == fcs_pkg::CMD_EXIT)
        begin
            result.next_mode = fcs_pkg::MODE_NORMAL;
        end
        else
        begin
            case (mode)
                fcs_pkg::MODE_NORMAL:
                begin
                    if (at_a && cmd == fcs_pkg::CMD_UNLOCK1)
                        result.next_mode = fcs_pkg::MODE_ENTER1;
                    else
                        result.seq_error = 1'b1;
                end
                fcs_pkg::MODE_ENTER1:
                begin
                    if (at_b && cmd == fcs_pkg::CMD_UNLOCK2)
                        result.next_mode = fcs_pkg::MODE_ENTER2;
                    else
                        result.seq_error = 1'b1;
                end
                fcs_pkg::MODE_ENTER2:
                begin
                    if (!at_a)
                        result.seq_error = 1'b1;
                    else if (cmd == fcs_pkg::CMD_ERASE)
                        result.next_mode = fcs_pkg::MODE_ENTER3;
                    else if (cmd inside {fcs_pkg::CMD_ID, fcs_pkg::CMD_QUERY})
                        result.next_mode = fcs_pkg::MODE_QUERY;
                    else if (cmd == fcs_pkg::CMD_PROGRAM)
                        result.next_mode = fcs_pkg::MODE_PROGRAM;
                    else
                        result.seq_error = 1'b1;
                end
                fcs_pkg::MODE_ENTER3:
                begin
                    if (at_a && cmd == fcs_pkg::CMD_UNLOCK1)
                        result.next_mode = fcs_pkg::MODE_ENTER4;
                    else
                        result.seq_error = 1'b1;
                end
                fcs_pkg::MODE_ENTER4:
                begin
                    if (at_b && cmd == fcs_pkg::CMD_UNLOCK2)
                        result.next_mode = fcs_pkg::MODE_ENTER5;
                    else
                        result.seq_error = 1'b1;
                end
                fcs_pkg::MODE_ENTER5:
                begin
                    if (cmd == fcs_pkg::CMD_CHIP && at_a)
                    begin
                        result.kind = fcs_pkg::OP_CHIP;
                    end
                    else if (cmd == fcs_pkg::CMD_SECTOR)
                    begin
                        result.kind    = fcs_pkg::OP_SECTOR;
                        result.address = addr & fcs_pkg::SECTOR_ALIGN;
                    end
                    else if (cmd == fcs_pkg::CMD_BLOCK)
                    begin
                        result.kind    = fcs_pkg::OP_BLOCK;
                        result.address = addr & fcs_pkg::BLOCK_ALIGN;
                    end
                    else
                    begin
                        result.seq_error = 1'b1;
                    end
                end
                fcs_pkg::MODE_QUERY:
                begin
                    if ((at_a && cmd == fcs_pkg::CMD_UNLOCK1) ||
                        (at_b && cmd == fcs_pkg::CMD_UNLOCK2))
                        result.next_mode = fcs_pkg::MODE_QUERY;
                    else
                        result.seq_error = 1'b1;
                end
                fcs_pkg::MODE_PROGRAM:
                begin
                    result.kind    = fcs_pkg::OP_PROGRAM;
                    result.address = addr;
                    result.data    = data;
                end
                default:
                begin
                    result.seq_error = 1'b1;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== verif/fcs_op_tracker_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fcs_op_tracker_pkg: expected operations of the flash command sequencer
// Follows the unlock/command decode for every accepted bus write, keeps the
// operations still due in order, and compares each one the block returns.
// ----------------------------------------------------------------------------
package fcs_op_tracker_pkg;

    import fcs_pkg::*;

    class op_tracker;

        typedef struct {
            op_kind_t               kind;
            logic [ADDR_BITS-1:0]   address;
            logic [DATA_BITS-1:0]   data;
            logic [MODE_W-1:0]      mode;
            logic                   seq_error;
        } op_expect_t;

        logic [SIZE_W-1:0]  size_bits;
        logic [MODE_W-1:0]  mode;
        op_expect_t         pending_ops[$];
        int unsigned        failures;
        int unsigned        ops_checked;
        int unsigned        errors_seen;
        int unsigned        kind_seen[5];

        function new();
            size_bits   = SIZE_RESET;
            mode        = M_CODE_NORMAL;
            failures    = 0;
            ops_checked = 0;
            errors_seen = 0;
            foreach (kind_seen[i])
            begin
                kind_seen[i] = 0;
            end
        endfunction

        function void set_size(logic [SIZE_W-1:0] bits);
            size_bits = bits;
        endfunction

        function logic [ADDR_BITS-1:0] addr_mask();
            int unsigned    eff;
            logic [31:0]    m;
            eff = size_bits;
            if (eff > ADDR_BITS)
            begin
                eff = ADDR_BITS;
            end
            m = (32'd1 << eff) - 32'd1;
            return m[ADDR_BITS-1:0];
        endfunction

        function int unsigned backlog();
            return pending_ops.size();
        endfunction

        function void note_write(logic [ADDR_BITS-1:0] offset, logic [DATA_BITS-1:0] wdata);
            logic [ADDR_BITS-1:0]   a;
            logic [CMD_BITS-1:0]    c;
            op_expect_t             e;
            a           = offset & addr_mask();
            c           = wdata[CMD_BITS-1:0];
            e.kind      = OP_NONE;
            e.address   = '0;
            e.data      = '0;
            e.mode      = M_CODE_NORMAL;
            e.seq_error = 1'b0;
            if (mode != M_CODE_PROGRAM && c == CMD_EXIT)
            begin
                e.mode = M_CODE_NORMAL;
            end
            else
            begin
                case (mode)
                    M_CODE_NORMAL:
                        if (a == UNLOCK_A && c == CMD_UNLOCK1) e.mode = M_CODE_ENTER1;
                        else e.seq_error = 1'b1;
                    M_CODE_ENTER1:
                        if (a == UNLOCK_B && c == CMD_UNLOCK2) e.mode = M_CODE_ENTER2;
                        else e.seq_error = 1'b1;
                    M_CODE_ENTER2:
                        if (a != UNLOCK_A) e.seq_error = 1'b1;
                        else if (c == CMD_ERASE) e.mode = M_CODE_ENTER3;
                        else if (c == CMD_ID || c == CMD_QUERY) e.mode = M_CODE_QUERY;
                        else if (c == CMD_PROGRAM) e.mode = M_CODE_PROGRAM;
                        else e.seq_error = 1'b1;
                    M_CODE_ENTER3:
                        if (a == UNLOCK_A && c == CMD_UNLOCK1) e.mode = M_CODE_ENTER4;
                        else e.seq_error = 1'b1;
                    M_CODE_ENTER4:
                        if (a == UNLOCK_B && c == CMD_UNLOCK2) e.mode = M_CODE_ENTER5;
                        else e.seq_error = 1'b1;
                    M_CODE_ENTER5:
                        if (c == CMD_CHIP && a == UNLOCK_A)
                        begin
                            e.kind = OP_CHIP;
                        end
                        else if (c == CMD_SECTOR)
                        begin
                            e.kind    = OP_SECTOR;
                            e.address = a & SECTOR_ALIGN;
                        end
                        else if (c == CMD_BLOCK)
                        begin
                            e.kind    = OP_BLOCK;
                            e.address = a & BLOCK_ALIGN;
                        end
                        else
                        begin
                            e.seq_error = 1'b1;
                        end
                    M_CODE_QUERY:
                        if ((a == UNLOCK_A && c == CMD_UNLOCK1) ||
                            (a == UNLOCK_B && c == CMD_UNLOCK2))
                            e.mode = M_CODE_QUERY;
                        else
                            e.seq_error = 1'b1;
                    default:
                    begin
                        e.kind    = OP_PROGRAM;
                        e.address = a;
                        e.data    = wdata;
                    end
                endcase
            end
            mode = e.mode;
            pending_ops.push_back(e);
        endfunction

        function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
            failures++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
        endfunction

        function void check_op(logic [KIND_W-1:0] kind, logic [ADDR_BITS-1:0] address,
                               logic [DATA_BITS-1:0] data, logic [MODE_W-1:0] mode_out,
                               logic seq_error);
            op_expect_t e;
            if (pending_ops.size() == 0)
            begin
                failures++;
                $display("%0t: operation with no write outstanding, kind %0d address %h",
                         $time, kind, address);
                return;
            end
            e = pending_ops.pop_front();
            ops_checked++;
            kind_seen[int'(e.kind)]++;
            if (e.seq_error)
            begin
                errors_seen++;
            end
            if (kind !== e.kind) report("op_kind", 32'(e.kind), 32'(kind));
            if (address !== e.address) report("op_address", 32'(e.address), 32'(address));
            if (data !== e.data) report("op_data", 32'(e.data), 32'(data));
            if (mode_out !== e.mode) report("mode", 32'(e.mode), 32'(mode_out));
            if (seq_error !== e.seq_error) report("seq_error", 32'(e.seq_error), 32'(seq_error));
        endfunction

    endclass

endpackage

// ===== verif/flash_command_sequencer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flash_command_sequencer_test: command sequencer regression
// Drives unlock, program, erase, query and exit sequences plus broken ones and
// noise through the write channel under several flash sizes and handshake
// pacings, and checks every returned operation against a tracked prediction.
// ----------------------------------------------------------------------------
module flash_command_sequencer_test;

    import fcs_pkg::*;
    import fcs_op_tracker_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_WRITES = 140;
    localparam int PHASES       = 6;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [SIZE_W-1:0]  cfg_wdata;

    fcs_wr_if wr_ch ();
    fcs_op_if op_ch ();

    op_tracker          ops;
    int unsigned        tx_idle;
    int unsigned        rx_idle;
    int unsigned        hold_request;
    int unsigned        writes_sent;
    int unsigned        stall_cycles;

    flash_command_sequencer dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr_ch),
        .op         (op_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (wr_ch.valid && wr_ch.ready)
            begin
                ops.note_write(wr_ch.offset, wr_ch.wdata);
            end
            if (op_ch.valid && op_ch.ready)
            begin
                ops.check_op(op_ch.op_kind, op_ch.op_address, op_ch.op_data,
                             op_ch.mode, op_ch.seq_error);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((wr_ch.valid && wr_ch.ready) || (op_ch.valid && op_ch.ready))
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Hold off the op channel for a requested stretch, else pace it at random
    initial
    begin
        int unsigned held;
        held = 0;
        op_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                held         = hold_request;
                hold_request = 0;
            end
            if (held != 0)
            begin
                op_ch.ready <= 1'b0;
                held--;
            end
            else
            begin
                op_ch.ready <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    task automatic send_write(input logic [ADDR_BITS-1:0] off, input logic [DATA_BITS-1:0] d);
        while ($urandom_range(99) < tx_idle)
        begin
            wr_ch.valid <= 1'b0;
            @(posedge clk);
        end
        wr_ch.valid  <= 1'b1;
        wr_ch.offset <= off;
        wr_ch.wdata  <= d;
        @(posedge clk);
        while (!wr_ch.ready)
        begin
            @(posedge clk);
        end
        writes_sent++;
    endtask

    function automatic logic [ADDR_BITS-1:0] alias_of(logic [ADDR_BITS-1:0] base);
        return base | (ADDR_BITS'($urandom) & ~ops.addr_mask());
    endfunction

    task automatic send_cmd(input logic [ADDR_BITS-1:0] base, input logic [CMD_BITS-1:0] c);
        send_write(alias_of(base), {8'($urandom), c});
    endtask

    task automatic erase_steps(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            case (i)
                0:       send_cmd(UNLOCK_A, CMD_UNLOCK1);
                1:       send_cmd(UNLOCK_B, CMD_UNLOCK2);
                2:       send_cmd(UNLOCK_A, CMD_ERASE);
                3:       send_cmd(UNLOCK_A, CMD_UNLOCK1);
                default: send_cmd(UNLOCK_B, CMD_UNLOCK2);
            endcase
        end
    endtask

    task automatic drain();
        wr_ch.valid <= 1'b0;
        @(posedge clk);
        while (ops.backlog() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] bits);
        drain();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= bits;
        @(posedge clk);
        ops.set_size(bits);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_sequence();
        int unsigned            pick;
        int unsigned            n;
        logic [CMD_BITS-1:0]    c;
        pick = $urandom_range(99);
        if (pick < 20)
        begin
            erase_steps(2);
            send_cmd(UNLOCK_A, CMD_PROGRAM);
            if ($urandom_range(9) == 0)
                send_write(ADDR_BITS'($urandom), {8'($urandom), CMD_EXIT});
            else
                send_write(ADDR_BITS'($urandom), DATA_BITS'($urandom));
        end
        else if (pick < 45)
        begin
            erase_steps(5);
            c = $urandom_range(1) ? CMD_SECTOR : CMD_BLOCK;
            send_write(ADDR_BITS'($urandom), {8'($urandom), c});
        end
        else if (pick < 53)
        begin
            erase_steps(5);
            send_cmd(UNLOCK_A, CMD_CHIP);
        end
        else if (pick < 65)
        begin
            erase_steps(2);
            send_cmd(UNLOCK_A, $urandom_range(1) ? CMD_QUERY : CMD_ID);
            n = $urandom_range(4);
            repeat (n)
            begin
                if ($urandom_range(1))
                    send_cmd(UNLOCK_A, CMD_UNLOCK1);
                else
                    send_cmd(UNLOCK_B, CMD_UNLOCK2);
            end
            if ($urandom_range(3) != 0)
                send_write(ADDR_BITS'($urandom), {8'($urandom), CMD_EXIT});
            else
                send_write(ADDR_BITS'($urandom), DATA_BITS'($urandom));
        end
        else if (pick < 75)
        begin
            erase_steps($urandom_range(1, 5));
            send_write(ADDR_BITS'($urandom), {8'($urandom), CMD_EXIT});
        end
        else if (pick < 85)
        begin
            erase_steps($urandom_range(0, 5));
            case ($urandom_range(9))
                0:       c = CMD_UNLOCK1;
                1:       c = CMD_UNLOCK2;
                2:       c = CMD_ERASE;
                3:       c = CMD_ID;
                4:       c = CMD_QUERY;
                5:       c = CMD_PROGRAM;
                6:       c = CMD_CHIP;
                7:       c = CMD_SECTOR;
                8:       c = CMD_BLOCK;
                default: c = 8'($urandom);
            endcase
            if ($urandom_range(1))
                send_write(ADDR_BITS'($urandom), {8'($urandom), c});
            else
                send_cmd($urandom_range(1) ? UNLOCK_A : UNLOCK_B, c);
        end
        else
        begin
            send_write(ADDR_BITS'($urandom), DATA_BITS'($urandom));
        end
    endtask

    initial
    begin
        logic [SIZE_W-1:0]  size_plan[PHASES];
        int unsigned        target;
        bit                 paused;
        ops          = new();
        size_plan    = '{5'd31, 5'd16, 5'd0, 5'd20, 5'd18, 5'd24};
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        wr_ch.valid  = 1'b0;
        wr_ch.offset = '0;
        wr_ch.wdata  = '0;
        tx_idle      = 0;
        rx_idle      = 0;
        hold_request = 0;
        writes_sent  = 0;
        stall_cycles = 0;
        paused       = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_write('1, '1);
        erase_steps(2);
        send_cmd(UNLOCK_A, CMD_PROGRAM);
        send_write('1, {8'hff, CMD_EXIT});
        erase_steps(5);
        send_write('1, {8'h00, CMD_SECTOR});
        erase_steps(5);
        send_write(24'h12_3456, {8'h5a, CMD_BLOCK});
        erase_steps(5);
        send_cmd(UNLOCK_A, CMD_CHIP);
        erase_steps(2);
        send_cmd(UNLOCK_A, CMD_ID);
        send_cmd(UNLOCK_B, CMD_UNLOCK2);
        send_write('0, {8'h00, CMD_EXIT});

        for (int p = 0; p < PHASES; p++)
        begin
            tx_idle = (p < 2) ? 32 : (p < 4) ? 64 : 0;
            rx_idle = (p < 2) ? 64 : (p < 4) ? 32 : 0;
            set_size(size_plan[p]);
            if (p == 1)
            begin
                hold_request = HOLD_CYCLES;
            end
            target = writes_sent + PHASE_WRITES;
            while (writes_sent < target)
            begin
                if (p == 3 && !paused && writes_sent + PHASE_WRITES / 2 >= target)
                begin
                    drain();
                    paused = 1'b1;
                end
                random_sequence();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("%0d writes checked across six flash sizes and three pacing mixes",
                 ops.ops_checked);
        $display("programs %0d, sector %0d, block %0d, chip %0d erases, %0d broken sequences",
                 ops.kind_seen[int'(OP_PROGRAM)], ops.kind_seen[int'(OP_SECTOR)],
                 ops.kind_seen[int'(OP_BLOCK)], ops.kind_seen[int'(OP_CHIP)],
                 ops.errors_seen);
        if (ops.failures == 0 && ops.backlog() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
